[rtl/assert_macros.svh]
// assertion macros shared by the tracker modules
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/crt_pkg.sv]
// chunk request tracker: shared types, constants and codes
// no dependencies
package crt_pkg;

  localparam int MAX_CHUNKS = 1024;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MAX_BURST  = 64;
  localparam int BURST_W    = $clog2(MAX_BURST);
  localparam int PEER_BITS  = 16;
  localparam int REQ_W      = 7;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;
  localparam int RETRY_W    = 4;
  localparam int ENTRY_W    = RETRY_W + TIME_W + PEER_BITS + 2;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_REQUESTED = 2'd1,
    ST_COMPLETE  = 2'd2,
    ST_FAILED    = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    FN_REQUEST = 3'd0,
    FN_RECEIVE = 3'd1,
    FN_DISCONN = 3'd2,
    FN_TIMEOUT = 3'd3,
    FN_MARK    = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    K_NOP, K_REQ, K_RECV, K_DISC, K_TMO, K_MARK
  } kind_t;

  typedef enum logic [2:0] {
    RC_DONE    = 3'd0,
    RC_ALREADY = 3'd1,
    RC_INVALID = 3'd2,
    RC_RETRY   = 3'd3,
    RC_HFAIL   = 3'd4,
    RC_WFAIL   = 3'd5
  } rc_t;

  typedef enum logic [1:0] {
    REG_CHUNK_COUNT = 2'd0,
    REG_PAR_LIMIT   = 2'd1,
    REG_MAX_RETRIES = 2'd2,
    REG_TIMEOUT     = 2'd3
  } reg_t;

  typedef struct packed {
    logic [RETRY_W-1:0]   retries;
    logic [TIME_W-1:0]    rtime;
    logic [PEER_BITS-1:0] peer;
    st_t                  st;
  } entry_t;

  typedef struct packed {
    kind_t                kind;
    logic [PEER_BITS-1:0] peer;
    logic [REQ_W-1:0]     cnt;
    logic [IDX_W-1:0]     idx;
    logic                 hash_ok;
    logic                 write_ok;
    logic [TIME_W-1:0]    now;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic [REQ_W-1:0]   par_lim;
    logic [RETRY_W-1:0] max_retries;
    logic [TMO_W-1:0]   timeout;
  } cfg_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

[rtl/crt_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module crt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/crt_front.sv]
// front end: accepts requests, decodes the operation, two-entry command queue
// depends on crt_pkg, assert_macros.svh
`include "assert_macros.svh"
module crt_front import crt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic [PEER_BITS-1:0] in_peer,
  input  logic [REQ_W-1:0]     in_cnt,
  input  logic [IDX_W-1:0]     in_idx,
  input  logic       in_hash_ok,
  input  logic       in_write_ok,
  input  logic [TIME_W-1:0]    in_now,
  input  back_stat_t stat,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       dec;

  always_comb begin
    dec          = '0;
    dec.peer     = in_peer;
    dec.cnt      = in_cnt;
    dec.idx      = in_idx;
    dec.hash_ok  = in_hash_ok;
    dec.write_ok = in_write_ok;
    dec.now      = in_now;
    unique case (in_func)
      FN_REQUEST: dec.kind = K_REQ;
      FN_RECEIVE: dec.kind = K_RECV;
      FN_DISCONN: dec.kind = K_DISC;
      FN_TIMEOUT: dec.kind = K_TMO;
      FN_MARK:    dec.kind = K_MARK;
      default:    dec.kind = K_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2) && !stat.clearing;
  assign push      = in_valid && in_ready;
  assign pop       = stat.pop;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

  `ASSERT_CLK(a_pop_nonempty, pop |-> (cnt_r != 2'd0), "pop from empty command queue")
  `ASSERT_CLK(a_cnt_bound, cnt_r <= 2'd2, "command queue overfilled")

endmodule

[rtl/crt_back.sv]
// back end: table scans, single-entry updates, totals and the result register
// depends on crt_pkg, crt_ram, assert_macros.svh
`include "assert_macros.svh"
module crt_back import crt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       clear_req,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output back_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output rc_t        out_code,
  output logic       out_avalid,
  output logic [IDX_W-1:0] out_aidx,
  output logic       out_last,
  output logic [CNT_W-1:0] out_pend,
  output logic [CNT_W-1:0] out_act,
  output logic [CNT_W-1:0] out_comp,
  output logic [CNT_W-1:0] out_fail,
  output logic       out_allc
);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_ONE  = 8'b0001_0000,
    S_OUT  = 8'b0010_0000,
    S_PRD  = 8'b0100_0000,
    S_PWR  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  rc_t    code_r, code_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               infl_r, infl_nxt;
  logic [IDX_W-1:0]   infl_idx_r, infl_idx_nxt;
  logic [REQ_W-1:0]   take_r, take_nxt, got_r, got_nxt, k_r, k_nxt;
  logic [3:0][CNT_W-1:0] tot_r, tot_nxt;

  logic               out_valid_r, out_valid_nxt;
  rc_t                o_code_r, o_code_nxt;
  logic               o_av_r, o_av_nxt, o_last_r, o_last_nxt;
  logic [IDX_W-1:0]   o_idx_r, o_idx_nxt;
  // totals captured with each result
  logic [3:0][CNT_W-1:0] o_tot_r, o_tot_nxt;

  // table ram
  logic               t_we, t_re;
  logic [IDX_W-1:0]   t_waddr, t_raddr;
  entry_t             t_wdata, t_rdata;
  // picked index ram
  logic               p_we, p_re;
  logic [BURST_W-1:0] p_waddr, p_raddr;
  logic [IDX_W-1:0]   p_wdata, p_rdata;

  crt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CHUNKS)) u_tab (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  crt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BURST)) u_pick (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  // entry update logic
  entry_t             ent_new;
  logic               ent_chg, ent_pick, bump_fail;
  logic [RETRY_W-1:0] r1;
  logic [TIME_W-1:0]  age;
  logic               out_free;
  logic [REQ_W-1:0]   avail;
  logic [REQ_W-1:0]   take_c;
  logic [CNT_W+1:0]   sum;

  always_comb begin
    r1 = (t_rdata.retries == '1) ? t_rdata.retries : t_rdata.retries + RETRY_W'(1);
    bump_fail = r1 >= cfg.max_retries;
    age = cmd_r.now - t_rdata.rtime;
  end

  always_comb begin
    ent_new  = t_rdata;
    ent_pick = 1'b0;
    code_nxt = code_r;
    unique case (cmd_r.kind)
      K_REQ: begin
        if (t_rdata.st == ST_PENDING && got_r < take_r) begin
          ent_new.st    = ST_REQUESTED;
          ent_new.peer  = cmd_r.peer;
          ent_new.rtime = cmd_r.now;
          ent_pick      = 1'b1;
        end
      end
      K_DISC: begin
        if (t_rdata.st == ST_REQUESTED && t_rdata.peer == cmd_r.peer) begin
          ent_new.st = ST_PENDING;
        end
      end
      K_TMO: begin
        if (t_rdata.st == ST_REQUESTED && !age[TIME_W-1] &&
            age > {{(TIME_W-TMO_W){1'b0}}, cfg.timeout}) begin
          ent_new.retries = r1;
          ent_new.st      = bump_fail ? ST_FAILED : ST_PENDING;
        end
      end
      K_RECV: begin
        if (t_rdata.st == ST_COMPLETE) begin
          code_nxt = RC_ALREADY;
        end else if (!cmd_r.hash_ok) begin
          ent_new.retries = r1;
          ent_new.st      = bump_fail ? ST_FAILED : ST_PENDING;
          code_nxt        = bump_fail ? RC_HFAIL : RC_RETRY;
        end else if (!cmd_r.write_ok) begin
          ent_new.st = ST_PENDING;
          code_nxt   = RC_WFAIL;
        end else begin
          ent_new.st = ST_COMPLETE;
        end
      end
      K_MARK: begin
        if (t_rdata.st == ST_COMPLETE) begin
          code_nxt = RC_ALREADY;
        end else if (cmd_r.hash_ok) begin
          ent_new.st = ST_COMPLETE;
        end
      end
      default: ;
    endcase
    ent_chg = ent_new != t_rdata;
  end

  always_comb begin
    avail  = ({4'b0, cfg.par_lim} > tot_r[ST_REQUESTED]) ?
             REQ_W'({4'b0, cfg.par_lim} - tot_r[ST_REQUESTED]) : '0;
    take_c = (cmd.cnt < avail) ? cmd.cnt : avail;
    if (take_c > REQ_W'(MAX_BURST)) begin
      take_c = REQ_W'(MAX_BURST);
    end
    sum = {2'b0, tot_r[0]} + {2'b0, tot_r[1]} + {2'b0, tot_r[2]} + {2'b0, tot_r[3]};
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    clr_nxt       = clr_r;
    iss_nxt       = iss_r;
    infl_nxt      = infl_r;
    infl_idx_nxt  = infl_idx_r;
    take_nxt      = take_r;
    got_nxt       = got_r;
    k_nxt         = k_r;
    tot_nxt       = tot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_code_nxt    = o_code_r;
    o_av_nxt      = o_av_r;
    o_idx_nxt     = o_idx_r;
    o_last_nxt    = o_last_r;
    o_tot_nxt     = o_tot_r;
    stat          = '0;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0;
    t_re = 1'b0; t_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0;
    p_re = 1'b0; p_raddr = '0;
    unique case (state_r)
      S_CLR: begin
        stat.clearing = 1'b1;
        t_we    = 1'b1;
        t_waddr = clr_r;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(MAX_CHUNKS - 1)) begin
          tot_nxt               = '0;
          tot_nxt[ST_PENDING]   = cfg.n;
          state_nxt             = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          stat.pop = 1'b1;
          cmd_nxt  = cmd;
          iss_nxt  = '0;
          infl_nxt = 1'b0;
          got_nxt  = '0;
          take_nxt = take_c;
          k_nxt    = '0;
          unique case (cmd.kind) inside
            K_REQ, K_DISC, K_TMO: state_nxt = S_SCAN;
            K_RECV, K_MARK: state_nxt = ({1'b0, cmd.idx} >= cfg.n) ? S_OUT : S_RD;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (iss_r < cfg.n) begin
          t_re         = 1'b1;
          t_raddr      = iss_r[IDX_W-1:0];
          infl_nxt     = 1'b1;
          infl_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt      = iss_r + CNT_W'(1);
        end else begin
          infl_nxt = 1'b0;
          if (!infl_r) begin
            state_nxt = (cmd_r.kind == K_REQ && got_r != '0) ? S_PRD : S_OUT;
          end
        end
        if (infl_r && ent_chg) begin
          t_we    = 1'b1;
          t_waddr = infl_idx_r;
          t_wdata = ent_new;
          tot_nxt[t_rdata.st] = tot_nxt[t_rdata.st] - CNT_W'(1);
          tot_nxt[ent_new.st] = tot_nxt[ent_new.st] + CNT_W'(1);
        end
        if (infl_r && ent_pick) begin
          p_we    = 1'b1;
          p_waddr = got_r[BURST_W-1:0];
          p_wdata = infl_idx_r;
          got_nxt = got_r + REQ_W'(1);
        end
      end
      S_RD: begin
        t_re      = 1'b1;
        t_raddr   = cmd_r.idx;
        state_nxt = S_ONE;
      end
      S_ONE: begin
        if (ent_chg) begin
          t_we    = 1'b1;
          t_waddr = cmd_r.idx;
          t_wdata = ent_new;
          tot_nxt[t_rdata.st] = tot_nxt[t_rdata.st] - CNT_W'(1);
          tot_nxt[ent_new.st] = tot_nxt[ent_new.st] + CNT_W'(1);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_code_nxt    = code_r;
          o_av_nxt      = 1'b0;
          o_idx_nxt     = '0;
          o_last_nxt    = 1'b1;
          o_tot_nxt     = tot_r;
          state_nxt     = S_IDLE;
        end
      end
      S_PRD: begin
        p_re      = 1'b1;
        p_raddr   = k_r[BURST_W-1:0];
        state_nxt = S_PWR;
      end
      S_PWR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_code_nxt    = RC_DONE;
          o_av_nxt      = 1'b1;
          o_idx_nxt     = p_rdata;
          o_last_nxt    = (k_r + REQ_W'(1)) == got_r;
          o_tot_nxt     = tot_r;
          k_nxt         = k_r + REQ_W'(1);
          state_nxt     = ((k_r + REQ_W'(1)) == got_r) ? S_IDLE : S_PRD;
        end
      end
      default: state_nxt = S_CLR;
    endcase
    if (clear_req) begin
      state_nxt = S_CLR;
      clr_nxt   = '0;
    end
  end

  // result code for the current request
  rc_t code_sel;
  always_comb begin
    code_sel = code_r;
    if (state_r == S_IDLE) begin
      code_sel = (cmd.kind == K_RECV || cmd.kind == K_MARK) &&
                 ({1'b0, cmd.idx} >= cfg.n) ? RC_INVALID : RC_DONE;
    end else if (state_r == S_ONE) begin
      code_sel = code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      tot_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      tot_r       <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    code_r     <= code_sel;
    iss_r      <= iss_nxt;
    infl_r     <= infl_nxt;
    infl_idx_r <= infl_idx_nxt;
    take_r     <= take_nxt;
    got_r      <= got_nxt;
    k_r        <= k_nxt;
    o_code_r   <= o_code_nxt;
    o_av_r     <= o_av_nxt;
    o_idx_r    <= o_idx_nxt;
    o_last_r   <= o_last_nxt;
    o_tot_r    <= o_tot_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_code   = o_code_r;
  assign out_avalid = o_av_r;
  assign out_aidx   = o_idx_r;
  assign out_last   = o_last_r;
  assign out_pend   = o_tot_r[ST_PENDING];
  assign out_act    = o_tot_r[ST_REQUESTED];
  assign out_comp   = o_tot_r[ST_COMPLETE];
  assign out_fail   = o_tot_r[ST_FAILED];
  assign out_allc   = (cfg.n != '0) && (o_tot_r[ST_COMPLETE] == cfg.n);

  `ASSERT_CLK(a_totals_sum, (state_r == S_IDLE) |-> (sum == {2'b0, cfg.n}), "status totals do not add up to entries in use")
  `ASSERT_CLK(a_emit_bound, (state_r == S_PWR) |-> (k_r < got_r), "emitting past the picked list")

endmodule

[rtl/chunk_request_tracker_top.sv]
// chunk request tracker top level: stream ports, apb register file, front and back
// depends on crt_pkg, crt_front, crt_back
//
// channel   direction  handshake                       payload
// in_       slave      in_tvalid / in_tready           tuser func, tdata operands
// out_      master     out_tvalid / out_tready         tuser result_code, tdata, tlast
// cfg_      apb        psel, penable, pwrite, pready   four registers at 4*i
//
// request, disconnect and timeout scan read one table entry per cycle from the
// single table ram, then give their result; a request that assigns chunks then reads
// each picked index back from the picked index ram and emits one result per chunk
// receive and mark existing: pop, read, update, result; out of range: pop, result
// after reset and after each chunk_count write a clearing pass of all 1024 entries runs
// over the table ram; no request is accepted until it ends; out_tready low holds results
module chunk_request_tracker_top import crt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // func
  input  logic [71:0] in_tdata,   // peer_id, request_count, chunk_idx, hash_ok,
                                  // write_ok, now_time, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // result_code
  output logic [55:0] out_tdata,  // assigned_valid, assigned_index, pending_count,
                                  // active_count, complete_count, failed_count,
                                  // all_complete
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CNT_W-1:0]   chunk_count_r;
  logic [REQ_W-1:0]   par_lim_r;
  logic [RETRY_W-1:0] max_retries_r;
  logic [TMO_W-1:0]   timeout_r;
  logic               wr;
  logic               clear_req;
  cfg_t               cfg;
  back_stat_t         stat;
  logic               cmd_valid;
  cmd_t               cmd;
  rc_t                code;
  logic [IDX_W-1:0]   aidx;
  logic               avalid, allc;
  logic [CNT_W-1:0]   pend, act, comp, fail;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign clear_req  = wr && (reg_t'(cfg_paddr[3:2]) == REG_CHUNK_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_count_r <= '0;
      par_lim_r     <= REQ_W'(8);
      max_retries_r <= RETRY_W'(3);
      timeout_r     <= TMO_W'(60);
    end else if (wr) begin
      unique case (reg_t'(cfg_paddr[3:2]))
        REG_CHUNK_COUNT: chunk_count_r <= cfg_pwdata[CNT_W-1:0];
        REG_PAR_LIMIT:   par_lim_r     <= cfg_pwdata[REQ_W-1:0];
        REG_MAX_RETRIES: max_retries_r <= cfg_pwdata[RETRY_W-1:0];
        REG_TIMEOUT:     timeout_r     <= cfg_pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_t'(cfg_paddr[3:2]))
      REG_CHUNK_COUNT: cfg_prdata = {{(32-CNT_W){1'b0}}, chunk_count_r};
      REG_PAR_LIMIT:   cfg_prdata = {{(32-REQ_W){1'b0}}, par_lim_r};
      REG_MAX_RETRIES: cfg_prdata = {{(32-RETRY_W){1'b0}}, max_retries_r};
      REG_TIMEOUT:     cfg_prdata = {{(32-TMO_W){1'b0}}, timeout_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.n           = (chunk_count_r > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                           : chunk_count_r;
    cfg.par_lim     = par_lim_r;
    cfg.max_retries = max_retries_r;
    cfg.timeout     = timeout_r;
  end

  crt_front u_front (
    .clk, .rst_n,
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tuser),
    .in_peer    (in_tdata[15:0]),
    .in_cnt     (in_tdata[22:16]),
    .in_idx     (in_tdata[32:23]),
    .in_hash_ok (in_tdata[33]),
    .in_write_ok(in_tdata[34]),
    .in_now     (in_tdata[66:35]),
    .stat, .cmd_valid, .cmd
  );

  crt_back u_back (
    .clk, .rst_n, .cfg, .clear_req, .cmd_valid, .cmd, .stat,
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (code),
    .out_avalid(avalid),
    .out_aidx  (aidx),
    .out_last  (out_tlast),
    .out_pend  (pend),
    .out_act   (act),
    .out_comp  (comp),
    .out_fail  (fail),
    .out_allc  (allc)
  );

  assign out_tuser = code;
  assign out_tdata = {allc, fail, comp, act, pend, aidx, avalid};

endmodule
